### design/mfmc_pkg.sv
package mfmc_pkg;

   // batch and channel setup
   localparam int SAMPLES_PER_READING = 8;
   localparam int CHANNEL_COUNT       = 4;

   // field widths
   localparam int SAMPLE_W = 12;
   localparam int CH_W     = 2;
   localparam int PCT_W    = 7;

   // calibration constants
   localparam int LEVEL_CH  = 4;
   localparam int DRY_RESET = 3000;
   localparam int WET_RESET = 1300;
   localparam int PCT_SCALE = 100;

   // counter widths
   localparam int CNT_W     = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
   localparam int NUM_W     = $clog2(((1 << SAMPLE_W) - 1) * PCT_SCALE + 1);
   localparam int DIV_CNT_W = $clog2(NUM_W);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_DRY_CH0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WET_CH0 = 3'd4;

   typedef struct packed {
      logic [CH_W-1:0]     sensor_channel;
      logic [SAMPLE_W-1:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic [CH_W-1:0]     result_channel;
      logic [SAMPLE_W-1:0] median_reading;
      logic [PCT_W-1:0]    moisture_percent;
   } rsp_type;

   // sorter commands
   typedef struct packed {
      logic load;
      logic compare;
      logic rotate;
   } sort_ctrl_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT,
      ST_CALC,
      ST_DIV,
      ST_WAIT,
      ST_OUT
   } state_type;

endpackage

### design/mfmc_sorter.sv
module mfmc_sorter
   import mfmc_pkg::*;
(
   input  logic                clock,
   input  sort_ctrl_type       ctrl,
   input  logic [SAMPLE_W-1:0] sample,
   output logic [SAMPLE_W-1:0] median
);

   logic [SAMPLE_W-1:0] smp_ff [SAMPLES_PER_READING];
   logic [SAMPLE_W-1:0] smp_in [SAMPLES_PER_READING];
   logic [SAMPLE_W-1:0] lo;
   logic [SAMPLE_W-1:0] hi;
   logic [SAMPLE_W:0]   mid_sum;

   // shared compare unit on the two head entries
   always_comb begin
      if (smp_ff[0] > smp_ff[1]) begin
         lo = smp_ff[1];
         hi = smp_ff[0];
      end else begin
         lo = smp_ff[0];
         hi = smp_ff[1];
      end
   end

   // shift in, bubble step (larger stays at head) or plain rotate
   always_comb begin
      smp_in = smp_ff;
      priority if (ctrl.load) begin
         for (int i = 0; i < SAMPLES_PER_READING - 1; i++) smp_in[i] = smp_ff[i+1];
         smp_in[SAMPLES_PER_READING-1] = sample;
      end else if (ctrl.compare) begin
         smp_in[0] = hi;
         for (int i = 1; i < SAMPLES_PER_READING - 1; i++) smp_in[i] = smp_ff[i+1];
         smp_in[SAMPLES_PER_READING-1] = lo;
      end else if (ctrl.rotate) begin
         for (int i = 0; i < SAMPLES_PER_READING - 1; i++) smp_in[i] = smp_ff[i+1];
         smp_in[SAMPLES_PER_READING-1] = smp_ff[0];
      end else begin
         // hold the batch
         smp_in = smp_ff;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff <= smp_in;
   end

   // median of the sorted batch
   always_comb begin
      if ((SAMPLES_PER_READING % 2) == 0) begin
         mid_sum = {1'b0, smp_ff[SAMPLES_PER_READING/2 - 1]}
                 + {1'b0, smp_ff[SAMPLES_PER_READING/2]};
      end else begin
         mid_sum = {smp_ff[SAMPLES_PER_READING/2], 1'b0};
      end
      median = mid_sum[SAMPLE_W:1];
   end

endmodule

### design/mfmc_divider.sv
module mfmc_divider
   import mfmc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    dividend,
   input  logic [SAMPLE_W-1:0] divisor,
   output logic [NUM_W-1:0]    quotient,
   output div_stat_type        stat
);

   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SAMPLE_W:0]    trial;
   logic [SAMPLE_W:0]    diff;
   logic                 fits;

   // one restoring step per cycle
   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

### design/median_filter_moisture_calibrate_top.sv
// Batched median filter with per-channel linear moisture calibration.
// Input channel req_*: one 12-bit sample and its sensor channel per transaction.
// Every 8 samples form a batch tagged with the channel of its first sample.
// After the last sample the batch is sorted by one shared compare unit
// (7 bubble passes), the median is mapped to percent as
// (median-dry)*100/(wet-dry) by a restoring divider and clamped to
// 0..100; equal dry and wet levels give 0.
// Result channel rsp_*: one transaction per batch. req_stall is high from the
// last sample of a batch until its result is put in the output register.
// The result waits in an output register; the next batch may be collected
// while it waits, and a finished batch holds in place until that register
// is free.
// Configuration port csr_*: index 0..3 dry level, 4..7 wet level, channel 0..3.
// Write it only while the block is idle.
// Reset (synchronous) restores dry 3000, wet 1300 and empties the batch.
module median_filter_moisture_calibrate_top
   import mfmc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SAMPLE_W-1:0]  csr_wdata
);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    step_ff, step_in;
   logic [CNT_W-1:0]    pass_ff, pass_in;
   logic [CH_W-1:0]     batch_ch_ff, batch_ch_in;
   logic [SAMPLE_W-1:0] med_ff, med_in;
   logic [SAMPLE_W-1:0] num_mag_ff, num_mag_in;
   logic                num_neg_ff, num_neg_in;
   logic [SAMPLE_W-1:0] den_mag_ff, den_mag_in;
   logic                den_neg_ff, den_neg_in;
   logic                den_zero_ff, den_zero_in;
   logic                ch_bad_ff, ch_bad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [SAMPLE_W-1:0] dry_ff [LEVEL_CH];
   logic [SAMPLE_W-1:0] wet_ff [LEVEL_CH];

   sort_ctrl_type       sort_ctrl;
   logic [SAMPLE_W-1:0] median;
   logic                div_start;
   logic [NUM_W-1:0]    quotient;
   div_stat_type        div_stat;
   logic                req_take;
   logic                rsp_free;
   logic [SAMPLE_W:0]   num_diff;
   logic [SAMPLE_W:0]   den_diff;
   logic [SAMPLE_W:0]   num_abs;
   logic [SAMPLE_W:0]   den_abs;
   logic [PCT_W-1:0]    pct;

   mfmc_sorter u_sorter (
      .clock  (clock),
      .ctrl   (sort_ctrl),
      .sample (req_data.adc_sample),
      .median (median)
   );

   mfmc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (NUM_W'(num_mag_ff) * NUM_W'(PCT_SCALE)),
      .divisor  (den_mag_ff),
      .quotient (quotient),
      .stat     (div_stat)
   );

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVEL_CH; i++) begin
            dry_ff[i] <= SAMPLE_W'(DRY_RESET);
            wet_ff[i] <= SAMPLE_W'(WET_RESET);
         end
      end else if (csr_we) begin
         if (csr_index < REG_WET_CH0) begin
            dry_ff[csr_index[1:0] - REG_DRY_CH0[1:0]] <= csr_wdata;
         end else begin
            wet_ff[csr_index[1:0] - REG_WET_CH0[1:0]] <= csr_wdata;
         end
      end
   end

   // signed differences as sign and magnitude
   always_comb begin
      num_diff = {1'b0, median} - {1'b0, dry_ff[batch_ch_ff]};
      den_diff = {1'b0, wet_ff[batch_ch_ff]} - {1'b0, dry_ff[batch_ch_ff]};
      num_abs  = num_diff[SAMPLE_W] ? -num_diff : num_diff;
      den_abs  = den_diff[SAMPLE_W] ? -den_diff : den_diff;
   end

   // clamp the quotient into percent
   always_comb begin
      if (den_zero_ff || ch_bad_ff || (num_neg_ff != den_neg_ff)) begin
         pct = '0;
      end else if (quotient > NUM_W'(PCT_SCALE)) begin
         pct = PCT_W'(PCT_SCALE);
      end else begin
         pct = quotient[PCT_W-1:0];
      end
   end

   // input is open only while collecting a batch
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      batch_ch_in  = batch_ch_ff;
      med_in       = med_ff;
      num_mag_in   = num_mag_ff;
      num_neg_in   = num_neg_ff;
      den_mag_in   = den_mag_ff;
      den_neg_in   = den_neg_ff;
      den_zero_in  = den_zero_ff;
      ch_bad_in    = ch_bad_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      sort_ctrl    = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               sort_ctrl.load = 1'b1;
               if (cnt_ff == '0) begin
                  batch_ch_in = req_data.sensor_channel;
               end
               if (cnt_ff == CNT_W'(SAMPLES_PER_READING - 1)) begin
                  cnt_in   = '0;
                  step_in  = '0;
                  pass_in  = '0;
                  state_in = (SAMPLES_PER_READING > 1) ? ST_SORT : ST_CALC;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_SORT: begin
            if (step_ff == CNT_W'(SAMPLES_PER_READING - 1)) begin
               sort_ctrl.rotate = 1'b1;
               step_in = '0;
               if (pass_ff == CNT_W'(SAMPLES_PER_READING - 2)) begin
                  state_in = ST_CALC;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end else begin
               sort_ctrl.compare = 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         ST_CALC: begin
            med_in      = median;
            num_neg_in  = num_diff[SAMPLE_W];
            num_mag_in  = num_abs[SAMPLE_W-1:0];
            den_neg_in  = den_diff[SAMPLE_W];
            den_mag_in  = den_abs[SAMPLE_W-1:0];
            den_zero_in = (den_diff == '0);
            ch_bad_in   = (32'(batch_ch_ff) >= CHANNEL_COUNT);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done && !div_stat.busy) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.result_channel   = batch_ch_ff;
               rsp_data_in.median_reading   = med_ff;
               rsp_data_in.moisture_percent = pct;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         step_ff      <= '0;
         pass_ff      <= '0;
         batch_ch_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         batch_ch_ff  <= batch_ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath holding registers
   always_ff @(posedge clock) begin
      med_ff      <= med_in;
      num_mag_ff  <= num_mag_in;
      num_neg_ff  <= num_neg_in;
      den_mag_ff  <= den_mag_in;
      den_neg_ff  <= den_neg_in;
      den_zero_ff <= den_zero_in;
      ch_bad_ff   <= ch_bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
